[rtl/dssl_pkg.sv]
// shared types and constants for the d-pad stick slew limiter
package dssl_pkg;

    // full-scale axis value in whole units
    localparam int AXIS_MAX = 1000;

    // width of every axis field on the ports
    localparam int AXIS_W = 11;

    // width of the magnitude registers
    localparam int MAG_W = 10;

    // width of the ramp time register
    localparam int RAMP_W = 14;

    // width of the elapsed time field
    localparam int DT_W = 12;

    // 1000 * 4095 fits in this many bits
    localparam int SCALED_DT_W = 22;

    // configuration register indexes
    typedef enum logic [2:0] {
        REG_PITCH_MAG    = 3'd0,
        REG_ROLL_MAG     = 3'd1,
        REG_YAW_MAG      = 3'd2,
        REG_THROTTLE_MAG = 3'd3,
        REG_RAMP_TIME    = 3'd4,
        REG_LR_IS_ROLL   = 3'd5,
        REG_NEUTRAL      = 3'd6
    } reg_idx_t;

    // per-lane control from the sequencer
    typedef struct packed {
        logic upd;     // take the new value this cycle
        logic centre;  // force the value to zero
        logic inc;     // positive direction held
        logic dec;     // negative direction held
    } lane_ctl_t;

endpackage

[rtl/dssl_div.sv]
// restoring divider, one quotient bit per cycle
module dssl_div import dssl_pkg::*; #(
    parameter int NUM_W = 30
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                start,
    input  logic [NUM_W-1:0]    num,
    input  logic [RAMP_W-1:0]   den,
    output logic                done,
    output logic [NUM_W-1:0]    quo,
    output logic [RAMP_W-1:0]   rem
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic              busy_reg;
    logic              done_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [NUM_W-1:0]  quo_reg, quo_next;
    logic [RAMP_W-1:0] rem_reg, rem_next;
    logic [RAMP_W:0]   trial;
    logic              fits;

    always_comb begin
        trial    = {rem_reg, quo_reg[NUM_W-1]};
        fits     = trial >= {1'b0, den};
        rem_next = fits ? RAMP_W'(trial - {1'b0, den}) : trial[RAMP_W-1:0];
        quo_next = {quo_reg[NUM_W-2:0], fits};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(NUM_W);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg <= num;
            rem_reg <= '0;
        end else if (busy_reg) begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    assign done = done_reg;
    assign quo  = quo_reg;
    assign rem  = rem_reg;

endmodule

[rtl/dssl_lane.sv]
// one axis: target, bounded step toward it, rounded readout
module dssl_lane import dssl_pkg::*; #(
    parameter int FRAC_BITS = 8
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  lane_ctl_t                  ctl,
    input  logic [MAG_W-1:0]           mag,
    input  logic [FRAC_BITS+11:0]      step_up,
    input  logic [FRAC_BITS+11:0]      step_dn,
    output logic signed [AXIS_W-1:0]   rounded
);

    localparam int VW = FRAC_BITS + 11;  // signed value width
    localparam int SW = FRAC_BITS + 12;  // step and distance width

    logic signed [VW-1:0] value_reg, value_next;
    logic [MAG_W-1:0]     mag_sat;
    logic signed [VW-1:0] mag_q;
    logic signed [VW-1:0] target;
    logic [VW-1:0]        abs_t, abs_v;
    logic [SW-1:0]        step;
    logic signed [SW:0]   v_ext, t_ext, delta;
    logic [SW-1:0]        adelta;
    logic [VW-1:0]        rnd_sum;
    logic [AXIS_W-1:0]    rnd_mag;

    always_comb begin
        mag_sat = (mag > MAG_W'(AXIS_MAX)) ? MAG_W'(AXIS_MAX) : mag;
        mag_q   = {1'b0, mag_sat, {FRAC_BITS{1'b0}}};
        if (ctl.inc && !ctl.dec) begin
            target = mag_q;
        end else if (ctl.dec && !ctl.inc) begin
            target = -mag_q;
        end else begin
            target = '0;
        end

        abs_t = target[VW-1] ? VW'(-target) : VW'(target);
        abs_v = value_reg[VW-1] ? VW'(-value_reg) : VW'(value_reg);
        // falling magnitude moves at double rate
        step  = (abs_t > abs_v) ? step_up : step_dn;

        v_ext  = {{2{value_reg[VW-1]}}, value_reg};
        t_ext  = {{2{target[VW-1]}}, target};
        delta  = t_ext - v_ext;
        adelta = delta[SW] ? SW'(-delta) : delta[SW-1:0];

        if (adelta <= step) begin
            value_next = target;
        end else if (!delta[SW]) begin
            value_next = VW'(v_ext + $signed({1'b0, step}));
        end else begin
            value_next = VW'(v_ext - $signed({1'b0, step}));
        end

        // round half away from zero
        rnd_sum = abs_v + (VW'(1) << (FRAC_BITS - 1));
        rnd_mag = rnd_sum[FRAC_BITS+AXIS_W-1:FRAC_BITS];
        rounded = value_reg[VW-1] ? $signed(-rnd_mag) : $signed(rnd_mag);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            value_reg <= '0;
        end else if (ctl.upd) begin
            value_reg <= ctl.centre ? '0 : value_next;
        end
    end

endmodule

[rtl/dssl_merge.sv]
// joins the lane readouts, applies throttle neutral and holds the result beat
module dssl_merge import dssl_pkg::*; (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      load,
    input  logic signed [AXIS_W-1:0]  pitch_r,
    input  logic signed [AXIS_W-1:0]  roll_r,
    input  logic signed [AXIS_W-1:0]  yaw_r,
    input  logic signed [AXIS_W-1:0]  throttle_r,
    input  logic signed [AXIS_W-1:0]  neutral,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic signed [AXIS_W-1:0]  m_pitch_out,
    output logic signed [AXIS_W-1:0]  m_roll_out,
    output logic signed [AXIS_W-1:0]  m_yaw_out,
    output logic signed [AXIS_W-1:0]  m_throttle_z
);

    logic signed [AXIS_W:0]   z_sum;
    logic signed [AXIS_W-1:0] z_clamp;
    logic                     valid_reg;
    logic signed [AXIS_W-1:0] pitch_reg, roll_reg, yaw_reg, thr_reg;

    always_comb begin
        z_sum = {neutral[AXIS_W-1], neutral} + {throttle_r[AXIS_W-1], throttle_r};
        if (z_sum > (AXIS_W+1)'(AXIS_MAX)) begin
            z_clamp = AXIS_W'(AXIS_MAX);
        end else if (z_sum < -(AXIS_W+1)'(AXIS_MAX)) begin
            z_clamp = -AXIS_W'(AXIS_MAX);
        end else begin
            z_clamp = z_sum[AXIS_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (load) begin
            valid_reg <= 1'b1;
        end else if (m_ready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            pitch_reg <= pitch_r;
            roll_reg  <= roll_r;
            yaw_reg   <= yaw_r;
            thr_reg   <= z_clamp;
        end
    end

    assign m_valid      = valid_reg;
    assign m_pitch_out  = pitch_reg;
    assign m_roll_out   = roll_reg;
    assign m_yaw_out    = yaw_reg;
    assign m_throttle_z = thr_reg;

endmodule

[rtl/dpad_stick_slew_limiter_core.sv]
// top level of the d-pad stick slew limiter
//
// s_ channel: one beat per control tick carrying the button states, the
// elapsed milliseconds and a centre request. m_ channel: one beat per input
// beat with rounded pitch, roll and yaw and the neutral-offset throttle.
// The apb port holds the seven setup registers at byte address 4*index;
// write them only while no tick is in flight.
//
// each tick runs from input beat to result beat through the serial divider
// that forms the step size 1000*dt/ramp, one quotient bit per cycle over
// 22+FRAC_BITS numerator bits, then through the lane update and output
// load states. the divider is shared: its
// quotient and remainder give both the rising and the double-rate falling
// step, and four axis lanes then move in parallel.
// a new tick is taken once the previous one has reached the output register,
// even if that result beat is still waiting; a stalled receiver holds the
// block only when a second result is ready to be loaded.
// reset zeroes all axis values, loads the register defaults and empties the
// output register.
module dpad_stick_slew_limiter_core import dssl_pkg::*; #(
    parameter int FRAC_BITS = 8
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    // apb setup port
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [4:0]                paddr,
    input  logic [31:0]               pwdata,
    output logic [31:0]               prdata,
    output logic                      pready,
    // tick input
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic                      s_select_held,
    input  logic                      s_a_held,
    input  logic                      s_b_held,
    input  logic                      s_up_held,
    input  logic                      s_down_held,
    input  logic                      s_left_held,
    input  logic                      s_right_held,
    input  logic                      s_slide_on,
    input  logic [DT_W-1:0]           s_elapsed_ms,
    input  logic                      s_centre_now,
    // result output
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic signed [AXIS_W-1:0]  m_pitch_out,
    output logic signed [AXIS_W-1:0]  m_roll_out,
    output logic signed [AXIS_W-1:0]  m_yaw_out,
    output logic signed [AXIS_W-1:0]  m_throttle_z
);

    localparam int NUM_W = SCALED_DT_W + FRAC_BITS;  // divider numerator
    localparam int SW    = FRAC_BITS + 12;           // saturated step width

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_UPD,
        ST_LOAD
    } state_t;

    // setup registers
    logic [MAG_W-1:0]          pitch_mag_reg, roll_mag_reg, yaw_mag_reg, thr_mag_reg;
    logic [RAMP_W-1:0]         ramp_reg;
    logic                      lr_roll_reg;
    logic signed [AXIS_W-1:0]  neutral_reg;
    logic                      cfg_wr;
    reg_idx_t                  cfg_idx;

    // sequencer
    state_t                    state_reg;
    logic                      accept;
    logic                      centre_reg;
    logic [3:0]                inc_reg, dec_reg;
    logic [3:0]                inc_next, dec_next;
    logic                      strafe;
    logic [SW-1:0]             step_up_reg, step_dn_reg;
    logic                      lanes_upd;
    logic                      out_load;

    // divider
    logic [RAMP_W-1:0]         ramp_eff;
    logic [SCALED_DT_W-1:0]    dt_scaled;
    logic [NUM_W-1:0]          div_num;
    logic                      div_done;
    logic [NUM_W-1:0]          div_quo;
    logic [RAMP_W-1:0]         div_rem;
    logic [NUM_W:0]            quo_dbl;
    logic [SW-1:0]             step_up_sat, step_dn_sat;

    // lanes: pitch, roll, yaw, throttle
    lane_ctl_t                 lane_ctl [4];
    logic [MAG_W-1:0]          lane_mag [4];
    logic signed [AXIS_W-1:0]  lane_rnd [4];

    // ---------------- apb setup port ----------------
    assign pready  = 1'b1;
    assign cfg_idx = reg_idx_t'(paddr[4:2]);
    assign cfg_wr  = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pitch_mag_reg <= MAG_W'(500);
            roll_mag_reg  <= MAG_W'(500);
            yaw_mag_reg   <= MAG_W'(500);
            thr_mag_reg   <= MAG_W'(500);
            ramp_reg      <= RAMP_W'(400);
            lr_roll_reg   <= 1'b0;
            neutral_reg   <= '0;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                REG_PITCH_MAG:    pitch_mag_reg <= pwdata[MAG_W-1:0];
                REG_ROLL_MAG:     roll_mag_reg  <= pwdata[MAG_W-1:0];
                REG_YAW_MAG:      yaw_mag_reg   <= pwdata[MAG_W-1:0];
                REG_THROTTLE_MAG: thr_mag_reg   <= pwdata[MAG_W-1:0];
                REG_RAMP_TIME:    ramp_reg      <= pwdata[RAMP_W-1:0];
                REG_LR_IS_ROLL:   lr_roll_reg   <= pwdata[0];
                REG_NEUTRAL:      neutral_reg   <= pwdata[AXIS_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            REG_PITCH_MAG:    prdata = 32'(pitch_mag_reg);
            REG_ROLL_MAG:     prdata = 32'(roll_mag_reg);
            REG_YAW_MAG:      prdata = 32'(yaw_mag_reg);
            REG_THROTTLE_MAG: prdata = 32'(thr_mag_reg);
            REG_RAMP_TIME:    prdata = 32'(ramp_reg);
            REG_LR_IS_ROLL:   prdata = 32'(lr_roll_reg);
            REG_NEUTRAL:      prdata = 32'(neutral_reg);
            default:          prdata = '0;
        endcase
    end

    // ---------------- tick intake ----------------
    assign s_ready = (state_reg == ST_IDLE);
    assign accept  = s_valid && s_ready;

    // left/right go to roll when the slide switch differs from the mode bit
    always_comb begin
        strafe   = s_slide_on ^ lr_roll_reg;
        inc_next = '0;
        dec_next = '0;
        if (!s_select_held) begin
            inc_next[0] = s_a_held;
            dec_next[0] = s_b_held;
            inc_next[1] = strafe && s_right_held;
            dec_next[1] = strafe && s_left_held;
            inc_next[2] = !strafe && s_right_held;
            dec_next[2] = !strafe && s_left_held;
            inc_next[3] = s_up_held;
            dec_next[3] = s_down_held;
        end
    end

    // step numerator: 1000 * dt in q format
    assign ramp_eff  = (ramp_reg == '0) ? RAMP_W'(1) : ramp_reg;
    assign dt_scaled = SCALED_DT_W'(s_elapsed_ms) * SCALED_DT_W'(AXIS_MAX);
    assign div_num   = {dt_scaled, {FRAC_BITS{1'b0}}};

    dssl_div #(
        .NUM_W (NUM_W)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (accept),
        .num     (div_num),
        .den     (ramp_eff),
        .done    (div_done),
        .quo     (div_quo),
        .rem     (div_rem)
    );

    // double-rate step: floor(2n/d) = 2q + (2r >= d); both saturate past any
    // possible distance so the lanes compare on a narrow word
    always_comb begin
        quo_dbl = {div_quo, 1'b0} + (NUM_W+1)'({div_rem, 1'b0} >= {1'b0, ramp_eff});
        step_up_sat = (|div_quo[NUM_W-1:SW]) ? '1 : div_quo[SW-1:0];
        step_dn_sat = (|quo_dbl[NUM_W:SW])   ? '1 : quo_dbl[SW-1:0];
    end

    // ---------------- sequencer ----------------
    assign lanes_upd = (state_reg == ST_UPD);
    assign out_load  = (state_reg == ST_LOAD) && (!m_valid || m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            unique case (state_reg)
                ST_IDLE: if (accept)   state_reg <= ST_DIV;
                ST_DIV:  if (div_done) state_reg <= ST_UPD;
                ST_UPD:                state_reg <= ST_LOAD;
                ST_LOAD: if (out_load) state_reg <= ST_IDLE;
                default:               state_reg <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            inc_reg    <= inc_next;
            dec_reg    <= dec_next;
            centre_reg <= s_centre_now;
        end
        if (div_done) begin
            step_up_reg <= step_up_sat;
            step_dn_reg <= step_dn_sat;
        end
    end

    // ---------------- axis lanes ----------------
    assign lane_mag[0] = pitch_mag_reg;
    assign lane_mag[1] = roll_mag_reg;
    assign lane_mag[2] = yaw_mag_reg;
    assign lane_mag[3] = thr_mag_reg;

    for (genvar i = 0; i < 4; i++) begin : g_lane
        assign lane_ctl[i] = '{upd: lanes_upd, centre: centre_reg,
                               inc: inc_reg[i], dec: dec_reg[i]};

        dssl_lane #(
            .FRAC_BITS (FRAC_BITS)
        ) u_lane (
            .aclk    (aclk),
            .aresetn (aresetn),
            .ctl     (lane_ctl[i]),
            .mag     (lane_mag[i]),
            .step_up (step_up_reg),
            .step_dn (step_dn_reg),
            .rounded (lane_rnd[i])
        );
    end

    // ---------------- merge and result register ----------------
    dssl_merge u_merge (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .load         (out_load),
        .pitch_r      (lane_rnd[0]),
        .roll_r       (lane_rnd[1]),
        .yaw_r        (lane_rnd[2]),
        .throttle_r   (lane_rnd[3]),
        .neutral      (neutral_reg),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_pitch_out  (m_pitch_out),
        .m_roll_out   (m_roll_out),
        .m_yaw_out    (m_yaw_out),
        .m_throttle_z (m_throttle_z)
    );

endmodule
